@@ design/abgt_pkg.sv @@
package abgt_pkg;

	// register map of the configuration port
	typedef enum logic [2:0] {
		REG_STEP_TIME,
		REG_HALF_STEP_SQ,
		REG_ALPHA_GAIN,
		REG_BETA_GAIN,
		REG_ACCEL_GAIN
	} cfg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int GAIN_W      = 18;
	localparam int IO_W        = 32;

	localparam logic [31:0]       STEP_TIME_RST    = 32'd3277;
	localparam logic [31:0]       HALF_STEP_SQ_RST = 32'd82;
	localparam logic [GAIN_W-1:0] ALPHA_GAIN_RST   = 18'd17760;
	localparam logic [GAIN_W-1:0] BETA_GAIN_RST    = 18'd1868;
	localparam logic [31:0]       ACCEL_GAIN_RST   = 32'd26214;

	localparam logic [IO_W-1:0] OUT_MAX = 32'h7fff_ffff;
	localparam logic [IO_W-1:0] OUT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0]       step_time;
		logic [31:0]       half_step_sq;
		logic [GAIN_W-1:0] alpha_gain;
		logic [GAIN_W-1:0] beta_gain;
		logic [31:0]       accel_gain;
	} cfg_t;

	// multiplier operand selects
	typedef enum logic [1:0] {A_VEL, A_ACC, A_RES} opa_sel_t;
	typedef enum logic [2:0] {B_DT, B_HALF, B_ALPHA, B_BETA, B_ACCEL} opb_sel_t;

	// accumulator controls
	typedef enum logic [2:0] {
		BASE_POS, BASE_VEL, BASE_ACC, BASE_PS, BASE_PV, BASE_MEAS, BASE_SUM
	} base_sel_t;
	typedef enum logic {ADD_PROD, ADD_NEG_PS} addend_sel_t;
	typedef enum logic [2:0] {
		DST_NONE, DST_PS, DST_PV, DST_RES, DST_POS, DST_VEL, DST_ACC
	} dest_sel_t;

	typedef enum logic {SEQ_NEXT, SEQ_END} seq_op_t;

	typedef struct packed {
		logic        mul_en;
		opa_sel_t    opa;
		opb_sel_t    opb;
		logic        acc_en;
		base_sel_t   base;
		addend_sel_t addend;
		dest_sel_t   dest;
		seq_op_t     seq;
	} uword_t;

	localparam int STEP_COUNT = 8;
	localparam int STEP_W     = $clog2(STEP_COUNT);
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic   step_en;
		logic   finish;
		uword_t uw;
	} seq_ctl_t;

	// microcode: a product issued in one step is consumed by the next step that adds a product
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		unique case (step)
			3'd0: w = '{mul_en: 1'b1, opa: A_VEL, opb: B_DT, acc_en: 1'b0,
				base: BASE_POS, addend: ADD_PROD, dest: DST_NONE, seq: SEQ_NEXT};
			3'd1: w = '{mul_en: 1'b1, opa: A_ACC, opb: B_HALF, acc_en: 1'b1,
				base: BASE_POS, addend: ADD_PROD, dest: DST_NONE, seq: SEQ_NEXT};
			3'd2: w = '{mul_en: 1'b1, opa: A_ACC, opb: B_DT, acc_en: 1'b1,
				base: BASE_SUM, addend: ADD_PROD, dest: DST_PS, seq: SEQ_NEXT};
			3'd3: w = '{mul_en: 1'b0, opa: A_ACC, opb: B_DT, acc_en: 1'b1,
				base: BASE_MEAS, addend: ADD_NEG_PS, dest: DST_RES, seq: SEQ_NEXT};
			3'd4: w = '{mul_en: 1'b1, opa: A_RES, opb: B_ALPHA, acc_en: 1'b1,
				base: BASE_VEL, addend: ADD_PROD, dest: DST_PV, seq: SEQ_NEXT};
			3'd5: w = '{mul_en: 1'b1, opa: A_RES, opb: B_BETA, acc_en: 1'b1,
				base: BASE_PS, addend: ADD_PROD, dest: DST_POS, seq: SEQ_NEXT};
			3'd6: w = '{mul_en: 1'b1, opa: A_RES, opb: B_ACCEL, acc_en: 1'b1,
				base: BASE_PV, addend: ADD_PROD, dest: DST_VEL, seq: SEQ_NEXT};
			3'd7: w = '{mul_en: 1'b0, opa: A_RES, opb: B_ACCEL, acc_en: 1'b1,
				base: BASE_ACC, addend: ADD_PROD, dest: DST_ACC, seq: SEQ_END};
		endcase
		return w;
	endfunction

endpackage

@@ design/abgt_if.sv @@
interface abgt_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measurement;
	logic               start_of_run;

	modport source (output valid, measurement, start_of_run, input ready);
	modport sink (input valid, measurement, start_of_run, output ready);
endinterface

interface abgt_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_position;
	logic               saturated;

	modport source (output valid, filtered_position, saturated, input ready);
	modport sink (input valid, filtered_position, saturated, output ready);
endinterface

@@ design/abgt_sequencer.sv @@
module abgt_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               out_free,
	output logic               busy,
	output abgt_pkg::seq_ctl_t ctl
);

	abgt_pkg::step_t  step_q;
	logic             busy_q;
	abgt_pkg::uword_t uw;
	logic             step_en;

	always_comb begin
		uw = abgt_pkg::ucode_rom(step_q);
		// the closing step waits for room in the result register
		step_en = busy_q && ((uw.seq == abgt_pkg::SEQ_NEXT) || out_free);
	end

	assign busy        = busy_q;
	assign ctl.step_en = step_en;
	assign ctl.finish  = step_en && (uw.seq == abgt_pkg::SEQ_END);
	assign ctl.uw      = uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (step_en) begin
			unique case (uw.seq)
				abgt_pkg::SEQ_NEXT: step_q <= step_q + 1'b1;
				abgt_pkg::SEQ_END: begin
					busy_q <= 1'b0;
					step_q <= '0;
				end
			endcase
		end
	end

endmodule

@@ design/abgt_datapath.sv @@
module abgt_datapath #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  abgt_pkg::cfg_t     cfg,
	input  logic               load,
	input  logic signed [31:0] measurement,
	input  logic               start_of_run,
	input  abgt_pkg::seq_ctl_t ctl,
	output logic signed [31:0] res_pos,
	output logic               res_sat
);

	localparam int DW = DATA_WIDTH;
	localparam int PW = DATA_WIDTH + 33;
	localparam int SW = DATA_WIDTH + 2;
	localparam int QW = PW - FRAC_BITS;
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	logic signed [DW-1:0] pos_q, vel_q, acc_q;
	logic signed [DW-1:0] ps_q, pv_q, res_q, meas_q;
	logic signed [SW-1:0] sum_q;
	logic signed [PW-1:0] prod_q;
	logic                 flag_q;
	logic signed [31:0]   res_pos_q;
	logic                 res_sat_q;

	logic signed [DW-1:0] opa;
	logic [32:0]          opb_u;
	logic signed [PW-1:0] prod_d;
	logic signed [PW-1:0] prod_bias;
	logic signed [QW-1:0] quo;
	logic                 prod_ovf;
	logic signed [DW-1:0] scaled;
	logic signed [SW-1:0] base_v, addend_v, sum_d;
	logic                 sum_ovf;
	logic signed [DW-1:0] sum_sat;
	logic                 step_flag;
	logic signed [PW-1:0] meas_ext;
	logic                 meas_ovf;
	logic signed [DW-1:0] meas_sat;
	logic signed [PW-1:0] pos_ext;
	logic                 out_ovf;
	logic signed [31:0]   out_val;

	function automatic logic signed [SW-1:0] sx(input logic signed [DW-1:0] v);
		return {{(SW-DW){v[DW-1]}}, v};
	endfunction

	// shared multiplier operands
	always_comb begin
		unique case (ctl.uw.opa)
			abgt_pkg::A_VEL: opa = vel_q;
			abgt_pkg::A_ACC: opa = acc_q;
			abgt_pkg::A_RES: opa = res_q;
			default:         opa = '0;
		endcase
		unique case (ctl.uw.opb)
			abgt_pkg::B_DT:    opb_u = 33'(cfg.step_time);
			abgt_pkg::B_HALF:  opb_u = 33'(cfg.half_step_sq);
			abgt_pkg::B_ALPHA: opb_u = 33'(cfg.alpha_gain);
			abgt_pkg::B_BETA:  opb_u = 33'(cfg.beta_gain);
			abgt_pkg::B_ACCEL: opb_u = 33'(cfg.accel_gain);
			default:           opb_u = '0;
		endcase
	end

	assign prod_d = opa * $signed(opb_u);

	// truncate toward zero, then clip to the data range
	assign prod_bias = prod_q
		+ $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{prod_q[PW-1]}}});
	assign quo      = prod_bias[PW-1:FRAC_BITS];
	assign prod_ovf = !((&quo[QW-1:DW-1]) || !(|quo[QW-1:DW-1]));
	assign scaled   = prod_ovf ? (quo[QW-1] ? MINV : MAXV) : quo[DW-1:0];

	always_comb begin
		unique case (ctl.uw.base)
			abgt_pkg::BASE_POS:  base_v = sx(pos_q);
			abgt_pkg::BASE_VEL:  base_v = sx(vel_q);
			abgt_pkg::BASE_ACC:  base_v = sx(acc_q);
			abgt_pkg::BASE_PS:   base_v = sx(ps_q);
			abgt_pkg::BASE_PV:   base_v = sx(pv_q);
			abgt_pkg::BASE_MEAS: base_v = sx(meas_q);
			abgt_pkg::BASE_SUM:  base_v = sum_q;
			default:             base_v = '0;
		endcase
		unique case (ctl.uw.addend)
			abgt_pkg::ADD_PROD:   addend_v = sx(scaled);
			abgt_pkg::ADD_NEG_PS: addend_v = -sx(ps_q);
		endcase
	end

	assign sum_d   = base_v + addend_v;
	assign sum_ovf = !((&sum_d[SW-1:DW-1]) || !(|sum_d[SW-1:DW-1]));
	assign sum_sat = sum_ovf ? (sum_d[SW-1] ? MINV : MAXV) : sum_d[DW-1:0];

	assign step_flag = ctl.uw.acc_en
		&& (((ctl.uw.addend == abgt_pkg::ADD_PROD) && prod_ovf)
		|| ((ctl.uw.dest != abgt_pkg::DST_NONE) && sum_ovf));

	assign meas_ext = {{(PW-32){measurement[31]}}, measurement};
	assign meas_ovf = !((&meas_ext[PW-1:DW-1]) || !(|meas_ext[PW-1:DW-1]));
	assign meas_sat = meas_ovf ? (meas_ext[PW-1] ? MINV : MAXV) : meas_ext[DW-1:0];

	// the emitted position is narrowed to the output width
	assign pos_ext = {{(PW-DW){pos_q[DW-1]}}, pos_q};
	assign out_ovf = !((&pos_ext[PW-1:31]) || !(|pos_ext[PW-1:31]));
	assign out_val = out_ovf ? (pos_ext[PW-1] ? abgt_pkg::OUT_MIN : abgt_pkg::OUT_MAX)
		: pos_ext[31:0];

	// estimates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
		end else if (load) begin
			if (start_of_run) begin
				pos_q <= '0;
				vel_q <= '0;
				acc_q <= '0;
			end
		end else if (ctl.step_en && ctl.uw.acc_en) begin
			unique case (ctl.uw.dest)
				abgt_pkg::DST_POS: pos_q <= sum_sat;
				abgt_pkg::DST_VEL: vel_q <= sum_sat;
				abgt_pkg::DST_ACC: acc_q <= sum_sat;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			meas_q <= meas_sat;
			flag_q <= meas_ovf;
		end else if (ctl.step_en) begin
			if (ctl.uw.mul_en) begin
				prod_q <= prod_d;
			end
			if (ctl.uw.acc_en) begin
				sum_q  <= sum_d;
				flag_q <= flag_q | step_flag;
				unique case (ctl.uw.dest)
					abgt_pkg::DST_PS:  ps_q  <= sum_sat;
					abgt_pkg::DST_PV:  pv_q  <= sum_sat;
					abgt_pkg::DST_RES: res_q <= sum_sat;
					default: ;
				endcase
			end
			if (ctl.finish) begin
				res_pos_q <= out_val;
				res_sat_q <= flag_q | step_flag | out_ovf;
			end
		end
	end

	assign res_pos = res_pos_q;
	assign res_sat = res_sat_q;

endmodule

@@ design/alpha_beta_gamma_tracker.sv @@
// alpha-beta-gamma tracker: each request carries one position sample (signed
// q16.16) and yields one corrected position with a saturation flag; a request
// is taken in, then runs eight steps of a microcode program that runs every
// product through a single shared multiplier (each product registered, then
// scaled and summed in the next step that adds a product); the next request is
// taken as soon as the program has finished, while the previous result may
// still sit in the output register; the closing step waits only if that
// register is still full; configuration is written through a plain write port
// and must only change while the block is idle
module alpha_beta_gamma_tracker #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [abgt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [abgt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	abgt_sample_if.sink                         samples,
	abgt_result_if.source                       results
);

	// configuration registers
	abgt_pkg::cfg_t     cfg_q;

	// handshake and sequencing
	logic               sample_fire;
	logic               busy;
	logic               out_free;
	logic               out_valid_q;
	abgt_pkg::seq_ctl_t seq_ctl;

	// result payload from the datapath
	logic signed [31:0] res_pos;
	logic               res_sat;

	// writes beyond the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time    <= abgt_pkg::STEP_TIME_RST;
			cfg_q.half_step_sq <= abgt_pkg::HALF_STEP_SQ_RST;
			cfg_q.alpha_gain   <= abgt_pkg::ALPHA_GAIN_RST;
			cfg_q.beta_gain    <= abgt_pkg::BETA_GAIN_RST;
			cfg_q.accel_gain   <= abgt_pkg::ACCEL_GAIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				abgt_pkg::REG_STEP_TIME:    cfg_q.step_time    <= cfg_wdata;
				abgt_pkg::REG_HALF_STEP_SQ: cfg_q.half_step_sq <= cfg_wdata;
				abgt_pkg::REG_ALPHA_GAIN:
					cfg_q.alpha_gain <= cfg_wdata[abgt_pkg::GAIN_W-1:0];
				abgt_pkg::REG_BETA_GAIN:
					cfg_q.beta_gain <= cfg_wdata[abgt_pkg::GAIN_W-1:0];
				abgt_pkg::REG_ACCEL_GAIN:   cfg_q.accel_gain   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a request is taken whenever the program is not running
	assign samples.ready = !busy;
	assign sample_fire   = samples.valid && samples.ready;

	// the result register is free when empty or being emptied this cycle
	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	abgt_sequencer u_sequencer (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sample_fire),
		.out_free (out_free),
		.busy     (busy),
		.ctl      (seq_ctl)
	);

	abgt_datapath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.load         (sample_fire),
		.measurement  (samples.measurement),
		.start_of_run (samples.start_of_run),
		.ctl          (seq_ctl),
		.res_pos      (res_pos),
		.res_sat      (res_sat)
	);

	assign results.valid             = out_valid_q;
	assign results.filtered_position = res_pos;
	assign results.saturated         = res_sat;

endmodule

@@ design/abgt_checker.sv @@
module abgt_checker (
	input logic clk,
	input logic arst_n,
	input logic smp_valid,
	input logic smp_ready,
	input logic res_valid,
	input logic res_ready
);

	logic       smp_fire;
	logic       res_fire;
	logic [1:0] pend_q;

	assign smp_fire = smp_valid && smp_ready;
	assign res_fire = res_valid && res_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, smp_fire} - {1'b0, res_fire};
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> pend_q != 2'd0)
		else $error("result without a pending request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two requests in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		smp_fire |=> !smp_ready)
		else $error("request taken while the program runs");

endmodule

bind alpha_beta_gamma_tracker abgt_checker u_abgt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (samples.valid),
	.smp_ready (samples.ready),
	.res_valid (results.valid),
	.res_ready (results.ready)
);

@@ dv/alpha_beta_gamma_tracker_tb.sv @@
module alpha_beta_gamma_tracker_tb;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// signed word range of the estimates
	localparam longint WORD_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;

	// margin for everything to settle once the block has gone quiet
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 4000;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 250;
	localparam int MAX_REPORTS   = 10;

	// phases with fixed register settings, the other later phases mix values per register
	localparam int PHASE_ALL_TOP  = 1;
	localparam int PHASE_ALL_ZERO = 2;

	// indexes past the register map, writes there must be ignored
	localparam logic [abgt_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [abgt_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum {VAL_TYPICAL, VAL_TOP, VAL_ZERO, VAL_RANDOM} value_kind_t;

	typedef struct packed {
		logic signed [31:0] measurement;
		logic               start_of_run;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] filtered_position;
		logic               saturated;
	} track_out_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [abgt_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [abgt_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	abgt_sample_if sample_ch ();
	abgt_result_if result_ch ();

	alpha_beta_gamma_tracker #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples  (sample_ch),
		.results  (result_ch)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// tracker mirror: register copies and the three estimates
	// ------------------------------------------------------------------
	logic [31:0]                 dt_q         = abgt_pkg::STEP_TIME_RST;
	logic [31:0]                 half_dt_sq_q = abgt_pkg::HALF_STEP_SQ_RST;
	logic [abgt_pkg::GAIN_W-1:0] alpha_q      = abgt_pkg::ALPHA_GAIN_RST;
	logic [abgt_pkg::GAIN_W-1:0] beta_q       = abgt_pkg::BETA_GAIN_RST;
	logic [31:0]                 accel_gain_q = abgt_pkg::ACCEL_GAIN_RST;

	longint pos_est = 0;
	longint vel_est = 0;
	longint acc_est = 0;
	logic   clip_seen;

	// clamp to the word range, noting any clip for this step
	function automatic longint clip_word(input longint v);
		if (v > WORD_MAX) begin
			clip_seen = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			clip_seen = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// signed estimate times unsigned coefficient, magnitude truncated, then clamped
	function automatic longint scale_mul(input longint s, input logic [31:0] u);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] lim;
		logic [63:0] q;
		neg = (s < 0);
		mag = neg ? 64'(-s) : 64'(s);
		lim = neg ? 64'(WORD_MAX) + 64'd1 : 64'(WORD_MAX);
		q   = (mag * {32'd0, u}) >> FRAC_BITS;
		if (q > lim) begin
			clip_seen = 1'b1;
			q = lim;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// one tracking step; with a 32-bit word the sample and the output never need
	// narrowing, so only the internal clamps can raise the flag
	function automatic track_out_t track_step(input logic signed [31:0] meas,
			input logic restart);
		longint     ps;
		longint     pv;
		longint     resid;
		track_out_t res;
		if (restart) begin
			pos_est = 0;
			vel_est = 0;
			acc_est = 0;
		end
		clip_seen = 1'b0;
		ps = clip_word(pos_est + scale_mul(vel_est, dt_q)
			+ scale_mul(acc_est, half_dt_sq_q));
		pv = clip_word(vel_est + scale_mul(acc_est, dt_q));
		resid = clip_word(longint'(meas) - ps);
		pos_est = clip_word(ps + scale_mul(resid, 32'(alpha_q)));
		vel_est = clip_word(pv + scale_mul(resid, 32'(beta_q)));
		acc_est = clip_word(acc_est + scale_mul(resid, accel_gain_q));
		res.filtered_position = pos_est[31:0];
		res.saturated         = clip_seen;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// bookkeeping shared by driver, monitor and sequencer
	// ------------------------------------------------------------------
	sample_t    sample_q[$];
	track_out_t expected_q[$];
	int         samples_sent  = 0;
	int         samples_taken = 0;
	int         results_seen  = 0;
	int         fault_count   = 0;
	int         stall_cycles  = 0;
	bit         steady_flow   = 1'b0;

	task automatic note_fault(input string what);
		if (fault_count < MAX_REPORTS)
			$display("%s", what);
		fault_count++;
	endtask

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// ------------------------------------------------------------------
	// request driver: changes inputs on the falling edge only
	// ------------------------------------------------------------------
	int      send_gap = 0;
	sample_t pending;

	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!(sample_ch.valid && samples_taken != samples_sent)) begin
			// previous request taken (or none out), so free to move on
			if (send_gap != 0) begin
				sample_ch.valid <= 1'b0;
				send_gap--;
			end else if (sample_q.size() != 0) begin
				pending = sample_q.pop_front();
				sample_ch.measurement  <= pending.measurement;
				sample_ch.start_of_run <= pending.start_of_run;
				sample_ch.valid        <= 1'b1;
				samples_sent++;
				send_gap = steady_flow ? 0 : pick_gap();
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result back-pressure: random stalls unless the phase runs at full flow
	int hold_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			hold_left = pick_gap();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks results first, then predicts for the accepted request,
	// and keeps the stall watchdog
	// ------------------------------------------------------------------
	track_out_t want;
	track_out_t got;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.filtered_position = result_ch.filtered_position;
				got.saturated         = result_ch.saturated;
				if (expected_q.size() == 0) begin
					note_fault($sformatf("unexpected result: position %h sat %b",
						got.filtered_position, got.saturated));
				end else begin
					want = expected_q.pop_front();
					if (got.filtered_position !== want.filtered_position
							|| got.saturated !== want.saturated)
						note_fault($sformatf(
							"result %0d: expected position %h sat %b, got position %h sat %b",
							results_seen, want.filtered_position, want.saturated,
							got.filtered_position, got.saturated));
				end
				results_seen++;
			end
			if (sample_ch.valid && sample_ch.ready) begin
				expected_q.push_back(track_step(sample_ch.measurement,
					sample_ch.start_of_run));
				samples_taken++;
			end
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_sample(input logic [31:0] meas, input logic restart);
		sample_t s;
		s.measurement  = meas;
		s.start_of_run = restart;
		sample_q.push_back(s);
	endtask

	// noisy constant-acceleration trajectory; a few carry on without restart
	task automatic add_track(input int len, input bit restart);
		longint origin;
		longint speed;
		longint accel;
		longint noise;
		longint pos;
		origin = longint'(int'($urandom)) >>> 3;
		speed  = longint'(int'($urandom)) >>> (($urandom_range(0, 7) == 0) ? 2 : 11);
		accel  = longint'(int'($urandom)) >>> 17;
		for (int t = 0; t < len; t++) begin
			noise = longint'(int'($urandom)) >>> $urandom_range(12, 31);
			pos = origin + speed * t + (accel * t * t) / 2 + noise;
			if (pos > WORD_MAX)
				pos = WORD_MAX;
			if (pos < WORD_MIN)
				pos = WORD_MIN;
			push_sample(pos[31:0], restart && t == 0);
		end
	endtask

	// mostly tracks with random content, the rest raw noise with stray restarts
	task automatic fill_phase(input int count);
		int queued;
		int len;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(3, 40);
				add_track(len, $urandom_range(0, 9) != 0);
				queued += len;
			end else begin
				push_sample($urandom, $urandom_range(0, 7) == 0);
				queued++;
			end
		end
	endtask

	// quiet point: nothing queued, nothing in flight, then a few spare cycles
	task automatic wait_idle();
		while (sample_q.size() != 0 || samples_taken != samples_sent
				|| expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write on the falling edge; the mirror follows at once since
	// the block is idle
	task automatic write_reg(input logic [abgt_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			abgt_pkg::REG_STEP_TIME:    dt_q         = data;
			abgt_pkg::REG_HALF_STEP_SQ: half_dt_sq_q = data;
			abgt_pkg::REG_ALPHA_GAIN:   alpha_q      = data[abgt_pkg::GAIN_W-1:0];
			abgt_pkg::REG_BETA_GAIN:    beta_q       = data[abgt_pkg::GAIN_W-1:0];
			abgt_pkg::REG_ACCEL_GAIN:   accel_gain_q = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic value_kind_t pick_kind(input int phase);
		if (phase == PHASE_ALL_TOP)
			return VAL_TOP;
		if (phase == PHASE_ALL_ZERO)
			return VAL_ZERO;
		case ($urandom_range(0, 9))
			0: return VAL_TOP;
			1: return VAL_ZERO;
			2, 3: return VAL_RANDOM;
			default: return VAL_TYPICAL;
		endcase
	endfunction

	// all ones also sets the bits above an 18-bit gain, which must be dropped
	function automatic logic [31:0] reg_value(input value_kind_t kind,
			input logic [31:0] typical);
		case (kind)
			VAL_TOP:    return 32'hffff_ffff;
			VAL_ZERO:   return 32'd0;
			VAL_RANDOM: return $urandom;
			default:    return $urandom_range(0, 4 * typical + 1);
		endcase
	endfunction

	task automatic reconfigure(input int phase);
		write_reg(abgt_pkg::REG_STEP_TIME,
			reg_value(pick_kind(phase), abgt_pkg::STEP_TIME_RST));
		write_reg(abgt_pkg::REG_HALF_STEP_SQ,
			reg_value(pick_kind(phase), abgt_pkg::HALF_STEP_SQ_RST));
		write_reg(abgt_pkg::REG_ALPHA_GAIN,
			reg_value(pick_kind(phase), 32'(abgt_pkg::ALPHA_GAIN_RST)));
		write_reg(abgt_pkg::REG_BETA_GAIN,
			reg_value(pick_kind(phase), 32'(abgt_pkg::BETA_GAIN_RST)));
		write_reg(abgt_pkg::REG_ACCEL_GAIN,
			reg_value(pick_kind(phase), abgt_pkg::ACCEL_GAIN_RST));
		// spare indexes get random data and must leave the map untouched
		for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
			write_reg(abgt_pkg::CFG_INDEX_W'(i), $urandom);
	endtask

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	initial begin
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = '0;
		cfg_wdata              = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.measurement  = '0;
		sample_ch.start_of_run = 1'b0;
		result_ch.ready        = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings
		push_sample(32'h0000_0000, 1'b1);
		// full-scale positive steps, then a swing to the most negative sample:
		// the residual overflows the word and clips
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h7fff_ffff, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'hffff_ffff, 1'b0);
		// restart while the estimates are far from zero
		push_sample(32'h0000_0001, 1'b1);
		push_sample(32'h8000_0000, 1'b1);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h7fff_ffff, 1'b0);
		// steady unit position from a clean start
		push_sample(32'h0001_0000, 1'b1);
		push_sample(32'h0001_0000, 1'b0);
		push_sample(32'h0001_0000, 1'b0);
		push_sample(32'h0001_0000, 1'b0);
		// alternating bit patterns
		push_sample(32'h5555_5555, 1'b0);
		push_sample(32'haaaa_aaaa, 1'b1);
		push_sample(32'h5555_5555, 1'b0);
		push_sample(32'h0000_0000, 1'b1);
		fill_phase(PHASE_ITEMS);

		// later phases: all registers at top, all at zero, then mixed settings
		for (int phase = 1; phase < NUM_PHASES; phase++) begin
			wait_idle();
			reconfigure(phase);
			steady_flow = ($urandom_range(0, 3) == 0);
			fill_phase(PHASE_ITEMS);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", expected_q.size()));
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
